>>> sv/som_bmu_pkg.sv
// Shared widths, token types and distance helpers for the best matching unit search.
`default_nettype none

package som_bmu_pkg;

	localparam int unsigned VAL_W     = 16;
	localparam int unsigned SQ_W      = 32;
	localparam int unsigned DIST_W    = 34;
	localparam int unsigned NODE_W    = 4;
	localparam int unsigned RC_W      = 2;
	localparam int unsigned MAX_ATTR  = 4;
	localparam int unsigned ROWS_DEF  = 4;
	localparam int unsigned COLS_DEF  = 4;
	localparam int unsigned ATTR_DEF  = 4;

	typedef logic [MAX_ATTR-1:0][VAL_W-1:0] lanes_t;
	typedef logic [MAX_ATTR-1:0][SQ_W-1:0]  sq_lanes_t;

	typedef struct packed {
		logic              have;
		logic [NODE_W-1:0] node;
		logic [RC_W-1:0]   row;
		logic [RC_W-1:0]   col;
		logic [DIST_W-1:0] dist_sq;
	} best_t;

	typedef struct packed {
		logic              vld;
		lanes_t            sample;
		logic              cand_vld;
		logic [NODE_W-1:0] cand_node;
		logic [RC_W-1:0]   cand_row;
		logic [RC_W-1:0]   cand_col;
		sq_lanes_t         sq;
		best_t             best;
	} tok_t;

	function automatic logic [SQ_W-1:0] sq_diff(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		logic [VAL_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

	function automatic best_t pick_best(input tok_t t);
		logic [DIST_W-1:0] sum;
		best_t             r;
		sum = '0;
		for (int k = 0; k < MAX_ATTR; k++) begin
			sum = sum + DIST_W'(t.sq[k]);
		end
		r = t.best;
		if (t.cand_vld && (!t.best.have || sum < t.best.dist_sq)) begin
			r.have    = 1'b1;
			r.node    = t.cand_node;
			r.row     = t.cand_row;
			r.col     = t.cand_col;
			r.dist_sq = sum;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/som_bmu_cell.sv
// One lattice node: holds its weights, squares the sample difference, folds in the neighbor's node.
`default_nettype none

module som_bmu_cell #(
	parameter int unsigned N_ATTR  = som_bmu_pkg::ATTR_DEF,
	parameter int unsigned NODE_ID = 0,
	parameter int unsigned ROW_ID  = 0,
	parameter int unsigned COL_ID  = 0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               wr_en,
	input  wire som_bmu_pkg::lanes_t wr_values,
	input  wire som_bmu_pkg::tok_t  tok_in,
	output som_bmu_pkg::tok_t       tok_out
);

	logic [N_ATTR-1:0][som_bmu_pkg::VAL_W-1:0] w_q;
	som_bmu_pkg::sq_lanes_t                      sq;
	som_bmu_pkg::tok_t                           tok_q;

	for (genvar k = 0; k < som_bmu_pkg::MAX_ATTR; k++) begin : g_lane
		if (k < N_ATTR) begin : g_on
			assign sq[k] = som_bmu_pkg::sq_diff(w_q[k], tok_in.sample[k]);
		end else begin : g_off
			assign sq[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else if (wr_en) begin
			for (int k = 0; k < N_ATTR; k++) begin
				w_q[k] <= wr_values[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.vld <= 1'b0;
		end else if (adv) begin
			tok_q.vld       <= tok_in.vld;
			tok_q.sample    <= tok_in.sample;
			tok_q.cand_vld  <= 1'b1;
			tok_q.cand_node <= som_bmu_pkg::NODE_W'(NODE_ID);
			tok_q.cand_row  <= som_bmu_pkg::RC_W'(ROW_ID);
			tok_q.cand_col  <= som_bmu_pkg::RC_W'(COL_ID);
			tok_q.sq        <= sq;
			tok_q.best      <= som_bmu_pkg::pick_best(tok_in);
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

>>> sv/som_bmu_out.sv
// Final compare for the last node and the result register.
`default_nettype none

module som_bmu_out (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            adv,
	input  wire som_bmu_pkg::tok_t               tok_in,
	input  wire logic                            out_stall,
	output logic                                 out_valid,
	output logic [som_bmu_pkg::NODE_W-1:0]       best_node,
	output logic [som_bmu_pkg::RC_W-1:0]         best_row,
	output logic [som_bmu_pkg::RC_W-1:0]         best_col,
	output logic [som_bmu_pkg::DIST_W-1:0]       best_dist_sq
);

	som_bmu_pkg::best_t res;
	som_bmu_pkg::best_t res_q;
	logic               vld_q;

	assign res = som_bmu_pkg::pick_best(tok_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv && tok_in.vld) begin
			vld_q <= 1'b1;
			res_q <= res;
		end else if (!out_stall) begin
			vld_q <= 1'b0;
		end
	end

	assign out_valid    = vld_q;
	assign best_node    = res_q.node;
	assign best_row     = res_q.row;
	assign best_col     = res_q.col;
	assign best_dist_sq = res_q.dist_sq;

endmodule

`default_nettype wire

>>> sv/som_best_matching_unit.sv
// Top level: chain of lattice node cells searching for the best matching unit.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------------
//  input   | in_valid  | in_stall  | req_type, node_index, value_0 .. value_3
//  output  | out_valid | out_stall | best_node, best_row, best_col, best_dist_sq
//
// A load writes the addressed cell's weights when it is accepted.
// A query walks the chain one cell per cycle while no stalled result holds the chain, through
// each cell's token register and then the result register; the input is held off while a query
// is in flight, so the next item can be taken in the same cycle the result appears.
// Reset clears all node weights and the valid bits of the chain and the result register.
// A stalled result holds the next query at the chain end and the input with it.
`default_nettype none

module som_best_matching_unit #(
	parameter int unsigned ROWS   = som_bmu_pkg::ROWS_DEF,
	parameter int unsigned COLS   = som_bmu_pkg::COLS_DEF,
	parameter int unsigned N_ATTR = som_bmu_pkg::ATTR_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                req_type,
	input  wire logic [som_bmu_pkg::NODE_W-1:0]      node_index,
	input  wire logic [som_bmu_pkg::VAL_W-1:0]       value_0,
	input  wire logic [som_bmu_pkg::VAL_W-1:0]       value_1,
	input  wire logic [som_bmu_pkg::VAL_W-1:0]       value_2,
	input  wire logic [som_bmu_pkg::VAL_W-1:0]       value_3,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [som_bmu_pkg::NODE_W-1:0]           best_node,
	output logic [som_bmu_pkg::RC_W-1:0]             best_row,
	output logic [som_bmu_pkg::RC_W-1:0]             best_col,
	output logic [som_bmu_pkg::DIST_W-1:0]           best_dist_sq
);

	localparam int unsigned NODES = ROWS * COLS;

	som_bmu_pkg::tok_t   chain [NODES+1];
	som_bmu_pkg::tok_t   head;
	som_bmu_pkg::lanes_t vals;
	logic                busy_q;
	logic                accept;
	logic                adv;

	assign vals     = {value_3, value_2, value_1, value_0};
	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign adv      = !(chain[NODES].vld && out_valid && out_stall);

	always_comb begin
		head        = '0;
		head.vld    = accept && req_type;
		head.sample = vals;
	end

	assign chain[0] = head;

	for (genvar i = 0; i < NODES; i++) begin : g_cell
		som_bmu_cell #(
			.N_ATTR  (N_ATTR),
			.NODE_ID (i),
			.ROW_ID  (i / COLS),
			.COL_ID  (i % COLS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.wr_en     (accept && !req_type && (32'(node_index) == 32'(i))),
			.wr_values (vals),
			.tok_in    (chain[i]),
			.tok_out   (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept && req_type) begin
			busy_q <= 1'b1;
		end else if (adv && chain[NODES].vld) begin
			busy_q <= 1'b0;
		end
	end

	som_bmu_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.tok_in       (chain[NODES]),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.best_node    (best_node),
		.best_row     (best_row),
		.best_col     (best_col),
		.best_dist_sq (best_dist_sq)
	);

endmodule

`default_nettype wire

>>> bench/som_bmu_checker.sv
// Request codes and the scoreboard that predicts and checks best matching unit results.
`timescale 1ns / 100ps

package som_bmu_req_pkg;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

endpackage

module som_bmu_checker #(
	parameter int unsigned ROWS   = som_bmu_pkg::ROWS_DEF,
	parameter int unsigned COLS   = som_bmu_pkg::COLS_DEF,
	parameter int unsigned N_ATTR = som_bmu_pkg::ATTR_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               req_type,
	input  logic [som_bmu_pkg::NODE_W-1:0]     node_index,
	input  logic [som_bmu_pkg::VAL_W-1:0]      value_0,
	input  logic [som_bmu_pkg::VAL_W-1:0]      value_1,
	input  logic [som_bmu_pkg::VAL_W-1:0]      value_2,
	input  logic [som_bmu_pkg::VAL_W-1:0]      value_3,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [som_bmu_pkg::NODE_W-1:0]     best_node,
	input  logic [som_bmu_pkg::RC_W-1:0]       best_row,
	input  logic [som_bmu_pkg::RC_W-1:0]       best_col,
	input  logic [som_bmu_pkg::DIST_W-1:0]     best_dist_sq,
	output int unsigned                        fail_count,
	output int unsigned                        results_due
);

	import som_bmu_pkg::*;
	import som_bmu_req_pkg::*;

	localparam int unsigned NODES       = ROWS * COLS;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [RC_W-1:0]   row;
		logic [RC_W-1:0]   col;
		logic [DIST_W-1:0] dist_sq;
	} match_t;

	lanes_t      weights [NODES];
	match_t      matches_due [$];
	int unsigned mismatches = 0;

	assign fail_count = mismatches;

	function automatic match_t nearest_node(input lanes_t sample);
		match_t            m;
		logic [DIST_W-1:0] sum_sq;
		logic [VAL_W-1:0]  diff;
		m = '0;
		for (int n = 0; n < NODES; n++) begin
			sum_sq = '0;
			for (int k = 0; k < N_ATTR && k < MAX_ATTR; k++) begin
				if (weights[n][k] >= sample[k]) begin
					diff = weights[n][k] - sample[k];
				end else begin
					diff = sample[k] - weights[n][k];
				end
				sum_sq = sum_sq + DIST_W'(diff) * DIST_W'(diff);
			end
			// keep the lowest index on a tie
			if (n == 0 || sum_sq < m.dist_sq) begin
				m.node    = NODE_W'(n);
				m.row     = RC_W'(n / COLS);
				m.col     = RC_W'(n % COLS);
				m.dist_sq = sum_sq;
			end
		end
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lanes_t sample;
		match_t want;
		if (!arst_n) begin
			for (int n = 0; n < NODES; n++) begin
				weights[n] = '0;
			end
			matches_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (matches_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: unexpected result node %0d row %0d col %0d dist %0d",
							$time, best_node, best_row, best_col, best_dist_sq);
					end
				end else begin
					want = matches_due.pop_front();
					if (best_node !== want.node || best_row !== want.row ||
						best_col !== want.col || best_dist_sq !== want.dist_sq) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: expected node %0d row %0d col %0d dist %0d",
								$time, want.node, want.row, want.col, want.dist_sq);
							$display("%0t:      got node %0d row %0d col %0d dist %0d",
								$time, best_node, best_row, best_col, best_dist_sq);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				sample = {value_3, value_2, value_1, value_0};
				if (req_type == REQ_QUERY) begin
					matches_due.push_back(nearest_node(sample));
				end else if (node_index < NODES) begin
					for (int k = 0; k < N_ATTR && k < MAX_ATTR; k++) begin
						weights[node_index][k] = sample[k];
					end
				end
			end
		end
		results_due = matches_due.size();
	end

endmodule

>>> bench/tb_som_best_matching_unit.sv
// Testbench top: clock, reset, load and query items, and the verdict for the search.
`timescale 1ns / 100ps

module tb_som_best_matching_unit;

	import som_bmu_pkg::*;
	import som_bmu_req_pkg::*;

	localparam int unsigned ROWS         = ROWS_DEF;
	localparam int unsigned COLS         = COLS_DEF;
	localparam int unsigned N_ATTR       = ATTR_DEF;
	localparam int unsigned NODES        = ROWS * COLS;
	localparam int unsigned CLK_PERIOD   = 8;
	localparam int unsigned RANDOM_ITEMS = 600;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = NODES + 8;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic              req_type   = 1'b0;
	logic [NODE_W-1:0] node_index = '0;
	logic [VAL_W-1:0]  value_0    = '0;
	logic [VAL_W-1:0]  value_1    = '0;
	logic [VAL_W-1:0]  value_2    = '0;
	logic [VAL_W-1:0]  value_3    = '0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [NODE_W-1:0] best_node;
	logic [RC_W-1:0]   best_row;
	logic [RC_W-1:0]   best_col;
	logic [DIST_W-1:0] best_dist_sq;

	bit          sender_gaps   = 1'b1;
	bit          receiver_gaps = 1'b1;
	bit          hold_now      = 1'b0;
	int unsigned fail_count;
	int unsigned results_due;
	int unsigned cycle_count   = 0;
	lanes_t      loaded [NODES];

	som_best_matching_unit #(
		.ROWS   (ROWS),
		.COLS   (COLS),
		.N_ATTR (N_ATTR)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.node_index   (node_index),
		.value_0      (value_0),
		.value_1      (value_1),
		.value_2      (value_2),
		.value_3      (value_3),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.best_node    (best_node),
		.best_row     (best_row),
		.best_col     (best_col),
		.best_dist_sq (best_dist_sq)
	);

	som_bmu_checker #(
		.ROWS   (ROWS),
		.COLS   (COLS),
		.N_ATTR (N_ATTR)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.node_index   (node_index),
		.value_0      (value_0),
		.value_1      (value_1),
		.value_2      (value_2),
		.value_3      (value_3),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.best_node    (best_node),
		.best_row     (best_row),
		.best_col     (best_col),
		.best_dist_sq (best_dist_sq),
		.fail_count   (fail_count),
		.results_due  (results_due)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic offer(input req_kind_t kind, input logic [NODE_W-1:0] idx, input lanes_t v);
		while (sender_gaps && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		node_index <= idx;
		value_0    <= v[0];
		value_1    <= v[1];
		value_2    <= v[2];
		value_3    <= v[3];
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		if (kind == REQ_LOAD) begin
			loaded[idx] = v;
		end
	endtask

	function automatic logic [VAL_W-1:0] near_value(input logic [VAL_W-1:0] base);
		case ($urandom_range(6))
			0: return '0;
			1: return '1;
			2: return base;
			3, 4: return base + VAL_W'($urandom_range(64)) - VAL_W'(32);
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// receiver: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_now) begin
				for (int c = 1; c < HOLD_CYCLES; c++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
				hold_now = 1'b0;
			end
			out_stall <= receiver_gaps && ($urandom_range(99) < 14);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		lanes_t      v;
		int unsigned anchor;
		for (int n = 0; n < NODES; n++) begin
			loaded[n] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cleared store, then extremes, ties and ignored index bits
		offer(REQ_QUERY, '0, '0);
		offer(REQ_QUERY, '1, '1);
		offer(REQ_LOAD, 4'd15, '1);
		offer(REQ_QUERY, '0, '1);
		offer(REQ_LOAD, 4'd3, {16'hDEF0, 16'h9ABC, 16'h5678, 16'h1234});
		offer(REQ_LOAD, 4'd9, {16'hDEF0, 16'h9ABC, 16'h5678, 16'h1234});
		offer(REQ_QUERY, 4'd9, {16'hDEF0, 16'h9ABC, 16'h5678, 16'h1234});
		offer(REQ_QUERY, 4'd5, '0);
		offer(REQ_LOAD, 4'd0, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
		offer(REQ_LOAD, 4'd6, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
		offer(REQ_QUERY, 4'hF, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
		offer(REQ_LOAD, 4'd10, {16'h0001, 16'h0001, 16'h0001, 16'h0001});
		offer(REQ_QUERY, 4'hA, {16'h0000, 16'h0000, 16'h0000, 16'h0001});
		offer(REQ_LOAD, 4'd4, {16'h0000, 16'h0000, 16'h2000, 16'h1000});
		offer(REQ_LOAD, 4'd7, {16'h0000, 16'h0000, 16'h2000, 16'h3000});
		offer(REQ_QUERY, 4'h6, {16'h0000, 16'h0000, 16'h2000, 16'h2000});
		offer(REQ_LOAD, 4'd12, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
		offer(REQ_QUERY, 4'h3, {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
		offer(REQ_QUERY, 4'hC, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sender_gaps   = !(i >= 200 && i < 330);
			receiver_gaps = sender_gaps;
			if (i == 420) begin
				hold_now = 1'b1;
			end
			anchor = $urandom_range(NODES - 1);
			if ($urandom_range(9) == 0) begin
				v = loaded[anchor];
			end else begin
				for (int k = 0; k < MAX_ATTR; k++) begin
					v[k] = near_value(loaded[anchor][k]);
				end
			end
			if ($urandom_range(99) < 45) begin
				offer(REQ_LOAD, NODE_W'($urandom_range(NODES - 1)), v);
			end else begin
				offer(REQ_QUERY, NODE_W'($urandom), v);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (results_due != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
sv/som_bmu_pkg.sv
sv/som_bmu_cell.sv
sv/som_bmu_out.sv
sv/som_best_matching_unit.sv
bench/som_bmu_checker.sv
bench/tb_som_best_matching_unit.sv
